@@ src/puf_pkg.sv @@
// ============================================================================
// puf_pkg
// Shared constants, request/status codes and controller state encoding for
// the persistent union-find unit.
// ============================================================================
package puf_pkg;

    // Default sizing
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_MAX_VERSIONS = 1024;
    localparam int DEF_POOL_NODES   = 16384;

    // Fixed port field widths
    localparam int REQ_W  = 2;
    localparam int ELEM_W = 10;
    localparam int VER_W  = 10;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 11;

    // Register reset value
    localparam logic [CFG_W-1:0] NUM_RESET = 11'd1024;

    // Leaf rank
    localparam logic [7:0] RANK_INIT = 8'd1;
    localparam logic [7:0] RANK_MAX  = 8'd255;

    // Request types
    localparam logic [REQ_W-1:0] REQ_MERGE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ROLLBACK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_BAD      = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Controller states
    typedef enum logic [3:0] {
        S_CLAMP,
        S_KICK,
        S_BUILD,
        S_IDLE,
        S_VER,
        S_ROOT,
        S_DESC,
        S_DESC_W,
        S_LEAF_W,
        S_DECIDE,
        S_DEPTH,
        S_PC,
        S_PC_W,
        S_RANK,
        S_COMMIT,
        S_DONE
    } state_t;

endpackage

@@ src/puf_build.sv @@
// ============================================================================
// puf_build
// Writes the version 0 segment tree into the node pool, one node per cycle,
// in pre-order starting at pool slot 1. A small stack of pending upper
// bounds replaces the recursion.
// ============================================================================
module puf_build #(
    parameter int MAX_ELEMENTS = puf_pkg::DEF_MAX_ELEMENTS,
    parameter int POOL_NODES   = puf_pkg::DEF_POOL_NODES,
    localparam int CAP = (POOL_NODES / 2 < MAX_ELEMENTS) ? POOL_NODES / 2 : MAX_ELEMENTS,
    localparam int CW  = $clog2(CAP + 1),
    localparam int EW  = $clog2(MAX_ELEMENTS),
    localparam int PW  = $clog2(POOL_NODES),
    localparam int NW  = EW + 8 + 2 * PW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CW-1:0] count,
    output logic          wr_en,
    output logic [PW-1:0] wr_addr,
    output logic [NW-1:0] wr_data,
    output logic          done
);
    import puf_pkg::*;

    localparam int SD  = $clog2(CAP) + 1;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    logic           busy_reg, busy_next;
    logic [CW-1:0]  lo_reg, lo_next;
    logic [CW-1:0]  hi_reg, hi_next;
    logic [PW-1:0]  me_reg, me_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [CW-1:0]  stack_reg [SD];
    logic           push;
    logic [CW:0]    sum;
    logic [CW-1:0]  mid;
    logic           inner;
    logic [SPW-1:0] sp_dec;

    // Split point of the current range
    assign sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid    = sum[CW:1];
    assign inner  = (hi_reg - lo_reg) > CW'(1);
    assign sp_dec = sp_reg - SPW'(1);

    // Node contents and traversal step
    always_comb
    begin
        busy_next = busy_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        me_next   = me_reg;
        sp_next   = sp_reg;
        push      = 1'b0;
        done      = 1'b0;
        wr_en     = busy_reg;
        wr_addr   = me_reg;
        if (inner)
        begin
            wr_data = {EW'(0), 8'd0, me_reg + PW'(1),
                       me_reg + PW'({mid - lo_reg, 1'b0})};
        end
        else
        begin
            wr_data = {EW'(lo_reg), RANK_INIT, PW'(0), PW'(0)};
        end
        if (start)
        begin
            busy_next = 1'b1;
            lo_next   = '0;
            hi_next   = count;
            me_next   = PW'(1);
            sp_next   = '0;
        end
        else if (busy_reg)
        begin
            me_next = me_reg + PW'(1);
            if (inner)
            begin
                push    = 1'b1;
                sp_next = sp_reg + SPW'(1);
                hi_next = mid;
            end
            else if (hi_reg == count)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
            else
            begin
                lo_next = hi_reg;
                hi_next = stack_reg[sp_dec[SIW-1:0]];
                sp_next = sp_dec;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sp_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            sp_reg   <= sp_next;
        end
    end

    // Range and stack registers
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        me_reg <= me_next;
        if (push)
        begin
            stack_reg[sp_reg[SIW-1:0]] <= hi_reg;
        end
    end

endmodule

@@ src/persistent_union_find_unit.sv @@
// ============================================================================
// persistent_union_find_unit
// Versioned disjoint-set store built on a path-copying segment tree.
// ============================================================================
// Usage:
//  - Request channel (in_valid/in_ready): req_type, base_version, elem_a,
//    elem_b. One request is worked on at a time; each successful one creates a version.
//  - Result channel (out_valid/out_ready): same_set, merged, new_version,
//    status. One result per request, held in an output register, so the
//    next request is taken while a result still waits for out_ready.
//  - Config channel (cfg_valid/cfg_ready, num_elements): accepted only when
//    idle; it clears the store and rebuilds version 0.
//  - Reset and every config write run a build sweep that writes the 2n-1
//    nodes of version 0 (n the element count, 1024 at reset) before
//    requests are accepted. Requests rejected on acceptance finish without
//    a memory access; a rollback only reads and commits a version root.
//    Merge and query walk to each element's root: every hop is a tree
//    descent over ceil(log2 n)+1 levels in the node pool memory, whose
//    single read port sets the pace. A joining merge adds a depth check, a
//    path copy and, for equal ranks below the maximum, a rank update.
//  - A stalled receiver holds one result; a second one waits in the
//    controller until the output register frees.
// ============================================================================
module persistent_union_find_unit #(
    parameter int MAX_ELEMENTS = puf_pkg::DEF_MAX_ELEMENTS,
    parameter int MAX_VERSIONS = puf_pkg::DEF_MAX_VERSIONS,
    parameter int POOL_NODES   = puf_pkg::DEF_POOL_NODES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [puf_pkg::CFG_W-1:0]  num_elements,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [puf_pkg::REQ_W-1:0]  req_type,
    input  logic [puf_pkg::VER_W-1:0]  base_version,
    input  logic [puf_pkg::ELEM_W-1:0] elem_a,
    input  logic [puf_pkg::ELEM_W-1:0] elem_b,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       same_set,
    output logic                       merged,
    output logic [puf_pkg::VER_W-1:0]  new_version,
    output logic [puf_pkg::STAT_W-1:0] status
);
    import puf_pkg::*;

    localparam int CAP = (POOL_NODES / 2 < MAX_ELEMENTS) ? POOL_NODES / 2 : MAX_ELEMENTS;
    localparam int CW  = $clog2(CAP + 1);
    localparam int EW  = $clog2(MAX_ELEMENTS);
    localparam int PW  = $clog2(POOL_NODES);
    localparam int PFW = $clog2(POOL_NODES + 1);
    localparam int VW  = $clog2(MAX_VERSIONS);
    localparam int VCW = $clog2(MAX_VERSIONS + 1);
    localparam int NW  = EW + 8 + 2 * PW;

    // Memories
    logic [NW-1:0] node_mem [POOL_NODES];
    logic [PW-1:0] ver_mem  [MAX_VERSIONS];
    logic [NW-1:0] nrd_reg;
    logic [PW-1:0] vrd_reg;

    logic          n_we;
    logic [PW-1:0] n_wa;
    logic [NW-1:0] n_wd;
    logic          v_we;
    logic [VW-1:0] v_wa;
    logic [PW-1:0] v_wd;

    // Controller registers
    state_t           state_reg, state_next;
    logic [CFG_W-1:0] num_reg, num_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [VCW-1:0]   vc_reg, vc_next;
    logic [PFW-1:0]   fill_reg, fill_next;
    logic [REQ_W-1:0] type_reg, type_next;
    logic [VW-1:0]    base_reg, base_next;
    logic [EW-1:0]    b_reg, b_next;
    logic [PW-1:0]    root_reg, root_next;
    logic [PW-1:0]    cur_reg, cur_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [EW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    hops_reg, hops_next;
    logic             phase_reg, phase_next;
    logic [EW-1:0]    pa_reg, pa_next;
    logic [EW-1:0]    pb_reg, pb_next;
    logic [7:0]       ha_reg, ha_next;
    logic [7:0]       hb_reg, hb_next;
    logic [PW-1:0]    tb_reg, tb_next;
    logic [EW-1:0]    link_reg, link_next;
    logic [CW-1:0]    d_reg, d_next;
    logic [PW-1:0]    nroot_reg, nroot_next;
    logic             rsame_reg, rsame_next;
    logic             rmerged_reg, rmerged_next;
    logic [VER_W-1:0] rnv_reg, rnv_next;
    logic [STAT_W-1:0] rstat_reg, rstat_next;

    // Output register
    logic              out_valid_reg;
    logic              same_reg, merged_reg;
    logic [VER_W-1:0]  nv_reg;
    logic [STAT_W-1:0] stat_reg;
    logic              load;

    // Build sequencer
    logic          bld_start;
    logic          bld_we;
    logic [PW-1:0] bld_wa;
    logic [NW-1:0] bld_wd;
    logic          bld_done;

    puf_build #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .POOL_NODES   (POOL_NODES)
    ) u_build (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (bld_start),
        .count   (cnt_reg),
        .wr_en   (bld_we),
        .wr_addr (bld_wa),
        .wr_data (bld_wd),
        .done    (bld_done)
    );

    // Node fields of the read word
    logic [EW-1:0] rd_par;
    logic [7:0]    rd_rank;
    logic [PW-1:0] rd_kid0, rd_kid1;
    assign rd_kid1 = nrd_reg[PW-1:0];
    assign rd_kid0 = nrd_reg[2*PW-1:PW];
    assign rd_rank = nrd_reg[2*PW+7:2*PW];
    assign rd_par  = nrd_reg[NW-1:2*PW+8];

    // Range split
    logic [CW:0]   sum;
    logic [CW-1:0] mid;
    logic          inner;
    logic          go_left;
    assign sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = sum[CW:1];
    assign inner   = (hi_reg - lo_reg) > CW'(1);
    assign go_left = 32'(pos_reg) < 32'(mid);

    // Request checks
    logic req_bad, req_full, cfg_acc, in_acc;
    assign req_bad = (req_type == REQ_BAD) || (32'(base_version) >= 32'(vc_reg)) ||
                     ((req_type != REQ_ROLLBACK) &&
                      ((32'(elem_a) >= 32'(cnt_reg)) || (32'(elem_b) >= 32'(cnt_reg))));
    assign req_full = 32'(vc_reg) >= MAX_VERSIONS;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = in_valid && in_ready;

    // Next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        num_next     = num_reg;
        cnt_next     = cnt_reg;
        vc_next      = vc_reg;
        fill_next    = fill_reg;
        type_next    = type_reg;
        base_next    = base_reg;
        b_next       = b_reg;
        root_next    = root_reg;
        cur_next     = cur_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pos_next     = pos_reg;
        hops_next    = hops_reg;
        phase_next   = phase_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        ha_next      = ha_reg;
        hb_next      = hb_reg;
        tb_next      = tb_reg;
        link_next    = link_reg;
        d_next       = d_reg;
        nroot_next   = nroot_reg;
        rsame_next   = rsame_reg;
        rmerged_next = rmerged_reg;
        rnv_next     = rnv_reg;
        rstat_next   = rstat_reg;
        bld_start    = 1'b0;
        load         = 1'b0;
        n_we         = bld_we;
        n_wa         = bld_wa;
        n_wd         = bld_wd;
        v_we         = 1'b0;
        v_wa         = VW'(vc_reg);
        v_wd         = nroot_reg;

        case (state_reg)
            // Saturate the element count
            S_CLAMP:
            begin
                if (num_reg == '0)
                begin
                    cnt_next = CW'(1);
                end
                else if (32'(num_reg) > CAP)
                begin
                    cnt_next = CW'(CAP);
                end
                else
                begin
                    cnt_next = CW'(num_reg);
                end
                state_next = S_KICK;
            end
            S_KICK:
            begin
                bld_start  = 1'b1;
                state_next = S_BUILD;
            end
            // Version 0 tree sweep
            S_BUILD:
            begin
                if (bld_done)
                begin
                    v_we       = 1'b1;
                    v_wa       = '0;
                    v_wd       = PW'(1);
                    fill_next  = PFW'({1'b0, cnt_reg, 1'b0});
                    vc_next    = VCW'(1);
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_acc)
                begin
                    num_next   = num_elements;
                    state_next = S_CLAMP;
                end
                else if (in_acc)
                begin
                    type_next    = req_type;
                    base_next    = VW'(base_version);
                    pos_next     = EW'(elem_a);
                    b_next       = EW'(elem_b);
                    rsame_next   = 1'b0;
                    rmerged_next = 1'b0;
                    rnv_next     = '0;
                    if (req_bad)
                    begin
                        rstat_next = ST_BAD;
                        state_next = S_DONE;
                    end
                    else if (req_full)
                    begin
                        rstat_next = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rstat_next = ST_OK;
                        state_next = S_VER;
                    end
                end
            end
            // Version root read in flight
            S_VER:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                root_next  = vrd_reg;
                nroot_next = vrd_reg;
                if (type_reg == REQ_ROLLBACK)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    phase_next = 1'b0;
                    hops_next  = '0;
                    cur_next   = vrd_reg;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    state_next = S_DESC;
                end
            end
            // Node read in flight
            S_DESC:
            begin
                state_next = inner ? S_DESC_W : S_LEAF_W;
            end
            S_DESC_W:
            begin
                if (go_left)
                begin
                    cur_next = rd_kid0;
                    hi_next  = mid;
                end
                else
                begin
                    cur_next = rd_kid1;
                    lo_next  = mid;
                end
                state_next = S_DESC;
            end
            // Leaf reached: hop to parent or finish this element
            S_LEAF_W:
            begin
                cur_next   = root_reg;
                lo_next    = '0;
                hi_next    = cnt_reg;
                state_next = S_DESC;
                if ((rd_par != pos_reg) && (hops_reg < cnt_reg))
                begin
                    pos_next  = rd_par;
                    hops_next = hops_reg + CW'(1);
                end
                else if (!phase_reg)
                begin
                    pa_next    = rd_par;
                    ha_next    = rd_rank;
                    phase_next = 1'b1;
                    pos_next   = b_reg;
                    hops_next  = '0;
                end
                else
                begin
                    pb_next    = rd_par;
                    hb_next    = rd_rank;
                    tb_next    = cur_reg;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (type_reg == REQ_QUERY)
                begin
                    rsame_next = (pa_reg == pb_reg);
                    state_next = S_COMMIT;
                end
                else if (pa_reg == pb_reg)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    // Lower rank hangs under higher rank
                    pos_next   = (ha_reg > hb_reg) ? pb_reg : pa_reg;
                    link_next  = (ha_reg > hb_reg) ? pa_reg : pb_reg;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    d_next     = CW'(1);
                    state_next = S_DEPTH;
                end
            end
            // Path length check against pool space
            S_DEPTH:
            begin
                if (inner)
                begin
                    d_next = d_reg + CW'(1);
                    if (go_left)
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid;
                    end
                end
                else if (32'(fill_reg) + 32'(d_reg) > POOL_NODES)
                begin
                    rstat_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = root_reg;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    nroot_next = PW'(fill_reg);
                    state_next = S_PC;
                end
            end
            S_PC:
            begin
                state_next = S_PC_W;
            end
            // Copy one node of the path
            S_PC_W:
            begin
                n_we      = 1'b1;
                n_wa      = PW'(fill_reg);
                fill_next = fill_reg + PFW'(1);
                if (inner)
                begin
                    if (go_left)
                    begin
                        n_wd     = {rd_par, rd_rank, PW'(fill_reg) + PW'(1), rd_kid1};
                        cur_next = rd_kid0;
                        hi_next  = mid;
                    end
                    else
                    begin
                        n_wd     = {rd_par, rd_rank, rd_kid0, PW'(fill_reg) + PW'(1)};
                        cur_next = rd_kid1;
                        lo_next  = mid;
                    end
                    state_next = S_PC;
                end
                else
                begin
                    n_wd         = {link_reg, rd_rank, rd_kid0, rd_kid1};
                    rmerged_next = 1'b1;
                    if ((ha_reg == hb_reg) && (hb_reg != RANK_MAX))
                    begin
                        state_next = S_RANK;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            // In-place rank bump on the surviving root leaf
            S_RANK:
            begin
                n_we       = 1'b1;
                n_wa       = tb_reg;
                n_wd       = {pb_reg, hb_reg + 8'd1, PW'(0), PW'(0)};
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                v_we       = 1'b1;
                rnv_next   = VER_W'(vc_reg);
                vc_next    = vc_reg + VCW'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLAMP;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLAMP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg       <= NUM_RESET;
            cnt_reg       <= '0;
            vc_reg        <= VCW'(1);
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            num_reg  <= num_next;
            cnt_reg  <= cnt_next;
            vc_reg   <= vc_next;
            fill_reg <= fill_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        base_reg    <= base_next;
        b_reg       <= b_next;
        root_reg    <= root_next;
        cur_reg     <= cur_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pos_reg     <= pos_next;
        hops_reg    <= hops_next;
        phase_reg   <= phase_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        ha_reg      <= ha_next;
        hb_reg      <= hb_next;
        tb_reg      <= tb_next;
        link_reg    <= link_next;
        d_reg       <= d_next;
        nroot_reg   <= nroot_next;
        rsame_reg   <= rsame_next;
        rmerged_reg <= rmerged_next;
        rnv_reg     <= rnv_next;
        rstat_reg   <= rstat_next;
        if (load)
        begin
            same_reg   <= rsame_reg;
            merged_reg <= rmerged_reg;
            nv_reg     <= rnv_reg;
            stat_reg   <= rstat_reg;
        end
    end

    // Node pool
    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            node_mem[n_wa] <= n_wd;
        end
        nrd_reg <= node_mem[cur_reg];
    end

    // Version root table
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            ver_mem[v_wa] <= v_wd;
        end
        vrd_reg <= ver_mem[base_reg];
    end

    assign out_valid   = out_valid_reg;
    assign same_set    = same_reg;
    assign merged      = merged_reg;
    assign new_version = nv_reg;
    assign status      = stat_reg;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the persistent union-find unit. It keeps its own
// versioned union-find store, predicts each result as requests are accepted,
// and checks results in order under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;
    import puf_pkg::*;

    localparam int POOL  = DEF_POOL_NODES;
    localparam int MAXV  = DEF_MAX_VERSIONS;
    localparam int MAXE  = DEF_MAX_ELEMENTS;

    typedef struct packed {
        logic              same_set;
        logic              merged;
        logic [VER_W-1:0]  new_version;
        logic [STAT_W-1:0] status;
    } answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   num_elements = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [REQ_W-1:0]   req_type = '0;
    logic [VER_W-1:0]   base_version = '0;
    logic [ELEM_W-1:0]  elem_a = '0;
    logic [ELEM_W-1:0]  elem_b = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               same_set;
    logic               merged;
    logic [VER_W-1:0]   new_version;
    logic [STAT_W-1:0]  status;

    // Shadow store
    int      tree_par [POOL];
    int      tree_rank[POOL];
    int      tree_lo  [POOL];
    int      tree_hi  [POOL];
    int      ver_root [MAXV];
    int      fill_ptr;
    int      ver_count;
    int      elem_total;

    answer_t pending_answers[$];
    int      errors = 0;
    int      requests_sent = 0;
    int      results_seen = 0;
    int      cfg_writes = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_left = 0;

    persistent_union_find_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .num_elements(num_elements),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .base_version(base_version), .elem_a(elem_a), .elem_b(elem_b),
        .out_valid(out_valid), .out_ready(out_ready), .same_set(same_set),
        .merged(merged), .new_version(new_version), .status(status)
    );

    always #5 clk = ~clk;

    function automatic int slot(int i);
        return (i < POOL) ? i : 0;
    endfunction

    function automatic int build_tree(int lo, int hi);
        int me;
        int mid;
        int l;
        int r;
        me = slot(fill_ptr);
        fill_ptr++;
        mid = (lo + hi) / 2;
        tree_lo[me] = 0;
        tree_hi[me] = 0;
        tree_par[me] = 0;
        tree_rank[me] = 0;
        if (hi - lo > 1)
        begin
            l = build_tree(lo, mid);
            r = build_tree(mid, hi);
            tree_lo[me] = l;
            tree_hi[me] = r;
        end
        else
        begin
            tree_rank[me] = 1;
            tree_par[me] = lo;
        end
        return me;
    endfunction

    function automatic void rebuild_store(logic [CFG_W-1:0] count);
        int n;
        n = count;
        if (n < 1) n = 1;
        if (n > MAXE) n = MAXE;
        if (n > POOL / 2) n = POOL / 2;
        elem_total = n;
        fill_ptr = 1;
        ver_count = 1;
        ver_root[0] = build_tree(0, n);
    endfunction

    // Descend to the leaf of pos; depth counts visited nodes
    function automatic int find_leaf(int root, int pos, output int depth);
        int lo;
        int hi;
        int cur;
        int mid;
        lo = 0;
        hi = elem_total;
        cur = slot(root);
        depth = 1;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (pos < mid)
            begin
                cur = slot(tree_lo[cur]);
                hi = mid;
            end
            else
            begin
                cur = slot(tree_hi[cur]);
                lo = mid;
            end
            depth++;
        end
        return cur;
    endfunction

    function automatic int find_root_leaf(int root, int pos);
        int leaf;
        int hops;
        int d;
        leaf = find_leaf(root, pos, d);
        hops = 0;
        while (tree_par[leaf] != pos && hops < elem_total)
        begin
            pos = tree_par[leaf];
            leaf = find_leaf(root, pos, d);
            hops++;
        end
        return leaf;
    endfunction

    function automatic void copy_node(int dst, int src);
        tree_par[dst] = tree_par[src];
        tree_rank[dst] = tree_rank[src];
        tree_lo[dst] = tree_lo[src];
        tree_hi[dst] = tree_hi[src];
    endfunction

    // Path copy toward pos, relink its parent, return new root
    function automatic int relink_path(int root, int pos, int val);
        int lo;
        int hi;
        int cur;
        int first;
        int made;
        int mid;
        int nxt;
        lo = 0;
        hi = elem_total;
        cur = slot(root);
        first = slot(fill_ptr);
        fill_ptr++;
        made = first;
        copy_node(made, cur);
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            nxt = slot(fill_ptr);
            fill_ptr++;
            if (pos < mid)
            begin
                hi = mid;
                cur = slot(tree_lo[cur]);
                copy_node(nxt, cur);
                tree_lo[made] = nxt;
            end
            else
            begin
                lo = mid;
                cur = slot(tree_hi[cur]);
                copy_node(nxt, cur);
                tree_hi[made] = nxt;
            end
            made = nxt;
        end
        tree_par[made] = val;
        return first;
    endfunction

    function automatic answer_t apply_request(logic [REQ_W-1:0] kind, int ver, int a, int b);
        answer_t ans;
        int base;
        int newroot;
        int ta;
        int tb;
        int ua;
        int ub;
        int child;
        int parent;
        int need;
        ans = '0;
        if (kind == REQ_BAD || ver >= ver_count ||
            (kind != REQ_ROLLBACK && (a >= elem_total || b >= elem_total)))
            ans.status = ST_BAD;
        else if (ver_count >= MAXV)
            ans.status = ST_FULL;
        else
        begin
            base = ver_root[ver];
            newroot = base;
            if (kind != REQ_ROLLBACK)
            begin
                ta = find_root_leaf(base, a);
                tb = find_root_leaf(base, b);
                ua = tree_par[ta];
                ub = tree_par[tb];
                if (kind == REQ_QUERY)
                    ans.same_set = (ua == ub);
                else if (ua != ub)
                begin
                    child = (tree_rank[ta] > tree_rank[tb]) ? ub : ua;
                    parent = (tree_rank[ta] > tree_rank[tb]) ? ua : ub;
                    void'(find_leaf(base, child, need));
                    if (fill_ptr + need > POOL)
                        ans.status = ST_FULL;
                    else
                    begin
                        // equal ranks bump the shared leaf in place
                        if (tree_rank[ta] == tree_rank[tb] && tree_rank[tb] < RANK_MAX)
                            tree_rank[tb]++;
                        newroot = relink_path(base, child, parent);
                        ans.merged = 1'b1;
                    end
                end
            end
            if (ans.status == ST_OK)
            begin
                ans.new_version = VER_W'(ver_count);
                ver_root[ver_count] = newroot;
                ver_count++;
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Send one request; valid stays up across back-to-back requests
    task automatic send_request(logic [REQ_W-1:0] kind, int ver, int a, int b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        base_version <= ver[VER_W-1:0];
        elem_a <= a[ELEM_W-1:0];
        elem_b <= b[ELEM_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        pending_answers.push_back(apply_request(kind, ver & 10'h3FF, a & 10'h3FF, b & 10'h3FF));
        requests_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_count(int value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        num_elements <= value[CFG_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        rebuild_store(value[CFG_W-1:0]);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls plus a counted long hold
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_answers.size() == 0)
                report_mismatch("unexpected result, status", status, 0);
            else
            begin
                want = pending_answers.pop_front();
                if (same_set !== want.same_set)
                    report_mismatch("same_set", same_set, want.same_set);
                if (merged !== want.merged)
                    report_mismatch("merged", merged, want.merged);
                if (new_version !== want.new_version)
                    report_mismatch("new_version", new_version, want.new_version);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
            end
        end
    end

    task automatic test_directed();
        write_count(8);
        send_request(REQ_QUERY, 0, 0, 7);
        send_request(REQ_MERGE, 0, 0, 1);
        send_request(REQ_MERGE, 1, 2, 3);
        send_request(REQ_MERGE, 2, 1, 3);     // equal ranks
        send_request(REQ_MERGE, 3, 0, 2);     // already together
        send_request(REQ_QUERY, 3, 0, 3);
        send_request(REQ_QUERY, 1, 0, 3);     // older version
        send_request(REQ_MERGE, 3, 7, 0);
        send_request(REQ_MERGE, 3, 5, 5);
        send_request(REQ_ROLLBACK, 2, 1023, 1023);
        send_request(REQ_BAD, 0, 0, 0);
        send_request(REQ_QUERY, 1023, 0, 0);  // version not created
        send_request(REQ_QUERY, 0, 8, 0);     // element past count
        send_request(REQ_MERGE, 0, 0, 1023);
        send_request(REQ_QUERY, 9, 7, 3);
        send_request(REQ_ROLLBACK, 9, 0, 0);
        write_count(0);                      // saturates to one element
        send_request(REQ_QUERY, 0, 0, 0);
        send_request(REQ_MERGE, 0, 0, 0);
        send_request(REQ_QUERY, 0, 1, 0);
        write_count(2047);                   // saturates to the maximum
        send_request(REQ_MERGE, 0, 1023, 0);
        send_request(REQ_QUERY, 1, 0, 1023);
        send_request(REQ_QUERY, 1, 512, 511);
    endtask

    task automatic test_random_phase(int idle, int stall, int count, int items);
        int pick;
        int v;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_count(count);
        repeat (items)
        begin
            pick = $urandom_range(99);
            v = $urandom_range(ver_count - 1);
            if (pick < 55)
                send_request(REQ_MERGE, v, $urandom_range(elem_total - 1),
                             $urandom_range(elem_total - 1));
            else if (pick < 80)
                send_request(REQ_QUERY, v, $urandom_range(elem_total - 1),
                             $urandom_range(elem_total - 1));
            else if (pick < 90)
                send_request(REQ_ROLLBACK, v, $urandom, $urandom);
            else
                send_request(REQ_W'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    // Long receiver hold while requests keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_count(16);
        hold_left = 600;
        repeat (8)
            send_request(REQ_MERGE, $urandom_range(ver_count - 1), $urandom_range(15),
                         $urandom_range(15));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        rebuild_store(NUM_RESET);
        test_directed();
        test_random_phase(0, 0, $urandom_range(2, 40), 165);
        test_random_phase(84, 0, $urandom_range(2, 40), 165);
        test_random_phase(0, 84, 1024, 165);
        test_random_phase(27, 27, $urandom_range(2, 200), 165);
        test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_results();
        $display("Covered %0d requests, %0d results, %0d element-count writes",
                 requests_sent, results_seen, cfg_writes);
        $display("Merge, query, rollback, bad requests, count saturation, stalls");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(80_000_000);
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

endmodule
